[src/calendar_date_up_down_counter_assert.svh]
// assertion macros for the calendar date counter
`ifndef CALENDAR_DATE_UP_DOWN_COUNTER_ASSERT_SVH
`define CALENDAR_DATE_UP_DOWN_COUNTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define CALDATE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date counter: implication violated");

// next-cycle implication, checked out of reset
`define CALDATE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date counter: next-cycle implication violated");

`else

`define CALDATE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CALDATE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/caldate_pkg.sv]
package caldate_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam int MAX_YEAR = 9999;

    // year modulo the 400-year gregorian cycle
    localparam int YEAR_CYCLE = 400;
    localparam int CENTURY    = 100;
    localparam int CYCLE_W    = 9;

    // floor(y / 400) == (y * RECIP_400) >> RECIP_SHIFT for every 14-bit y
    localparam int RECIP_400   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 21;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = 6;

    localparam int LONG_MONTH  = 31;
    localparam int SHORT_MONTH = 30;
    localparam int FEB_LEAP    = 29;
    localparam int FEB_PLAIN   = 28;
    localparam int LAST_MONTH  = 12;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_NEXT = 2'd1,
        MODE_PREV = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]         mode;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [QUOT_W-1:0]  quot;
    } t_s1_item;

    function automatic logic is_leap(input logic [CYCLE_W-1:0] m400);
        is_leap = (m400 == '0) ||
                  ((m400[1:0] == 2'b00) &&
                   (m400 != CYCLE_W'(CENTURY)) &&
                   (m400 != CYCLE_W'(2 * CENTURY)) &&
                   (m400 != CYCLE_W'(3 * CENTURY)));
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2: begin
                len = leap ? DAY_W'(FEB_LEAP) : DAY_W'(FEB_PLAIN);
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = DAY_W'(SHORT_MONTH);
            end
            default: begin
                len = DAY_W'(LONG_MONTH);
            end
        endcase
        month_length = len;
    endfunction

endpackage

[src/caldate_in_stage.sv]
module caldate_in_stage
    import caldate_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [DAY_W-1:0]   i_load_day,
    input  logic [MONTH_W-1:0] i_load_month,
    input  logic [YEAR_W-1:0]  i_load_year,
    input  logic               i_adv,
    output logic               o_s1_valid,
    output t_s1_item           o_s1_item
);

    logic              r_valid;
    t_s1_item          r_item;
    t_s1_item          n_item;
    logic [PROD_W-1:0] w_prod;

    assign o_in_ready = !r_valid || i_adv;

    // quotient of the load year by 400 by reciprocal multiply; the next stage forms the remainder
    assign w_prod = PROD_W'(i_load_year) * PROD_W'(RECIP_400);

    always_comb begin
        n_item.mode  = i_mode;
        n_item.day   = i_load_day;
        n_item.month = i_load_month;
        n_item.year  = i_load_year;
        n_item.quot  = w_prod[RECIP_SHIFT +: QUOT_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1_item  = r_item;

endmodule

[src/caldate_core.sv]
module caldate_core
    import caldate_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s1_valid,
    input  t_s1_item           i_s1_item,
    output logic               o_adv,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [DAY_W-1:0]   o_day,
    output logic [MONTH_W-1:0] o_month,
    output logic [YEAR_W-1:0]  o_year,
    output logic               o_bad_load,
    output logic               o_range_hit
);

    logic [DAY_W-1:0]   r_cur_day;
    logic [MONTH_W-1:0] r_cur_month;
    logic [YEAR_W-1:0]  r_cur_year;
    logic [CYCLE_W-1:0] r_cur_m400;
    logic               r_out_valid;
    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    logic               r_bad;
    logic               r_hit;

    logic [DAY_W-1:0]   n_day;
    logic [MONTH_W-1:0] n_month;
    logic [YEAR_W-1:0]  n_year;
    logic [CYCLE_W-1:0] n_m400;
    logic               n_bad;
    logic               n_hit;

    logic               w_fire;
    logic [YEAR_W-1:0]  w_cycle_base;
    logic [YEAR_W-1:0]  w_ld_rem;
    logic [CYCLE_W-1:0] w_ld_m400;
    logic               w_ld_ok;
    logic               w_cur_leap;
    logic [DAY_W-1:0]   w_cur_len;
    logic [MONTH_W-1:0] w_prev_month;

    assign o_adv  = !r_out_valid || i_out_ready;
    assign w_fire = i_s1_valid && o_adv;

    assign w_cycle_base = YEAR_W'(i_s1_item.quot) * YEAR_W'(YEAR_CYCLE);
    assign w_ld_rem     = i_s1_item.year - w_cycle_base;
    assign w_ld_m400    = w_ld_rem[CYCLE_W-1:0];

    assign w_ld_ok = (i_s1_item.month >= MONTH_W'(1)) &&
                     (i_s1_item.month <= MONTH_W'(LAST_MONTH)) &&
                     (i_s1_item.year <= YEAR_W'(MAX_YEAR)) &&
                     (i_s1_item.day >= DAY_W'(1)) &&
                     (i_s1_item.day <= month_length(i_s1_item.month, is_leap(w_ld_m400)));

    assign w_cur_leap   = is_leap(r_cur_m400);
    assign w_cur_len    = month_length(r_cur_month, w_cur_leap);
    assign w_prev_month = r_cur_month - MONTH_W'(1);

    always_comb begin
        n_day   = r_cur_day;
        n_month = r_cur_month;
        n_year  = r_cur_year;
        n_m400  = r_cur_m400;
        n_bad   = 1'b0;
        n_hit   = 1'b0;
        unique case (t_mode'(i_s1_item.mode))
            MODE_LOAD: begin
                if (w_ld_ok) begin
                    n_day   = i_s1_item.day;
                    n_month = i_s1_item.month;
                    n_year  = i_s1_item.year;
                    n_m400  = w_ld_m400;
                end else begin
                    n_bad = 1'b1;
                end
            end
            MODE_NEXT: begin
                if (r_cur_day >= w_cur_len) begin
                    if (r_cur_month >= MONTH_W'(LAST_MONTH)) begin
                        if (r_cur_year >= YEAR_W'(MAX_YEAR)) begin
                            n_hit = 1'b1;
                        end else begin
                            n_day   = DAY_W'(1);
                            n_month = MONTH_W'(1);
                            n_year  = r_cur_year + YEAR_W'(1);
                            n_m400  = (r_cur_m400 == CYCLE_W'(YEAR_CYCLE - 1)) ?
                                      '0 : r_cur_m400 + CYCLE_W'(1);
                        end
                    end else begin
                        n_day   = DAY_W'(1);
                        n_month = r_cur_month + MONTH_W'(1);
                    end
                end else begin
                    n_day = r_cur_day + DAY_W'(1);
                end
            end
            MODE_PREV: begin
                if (r_cur_day <= DAY_W'(1)) begin
                    if (r_cur_month <= MONTH_W'(1)) begin
                        if (r_cur_year == '0) begin
                            n_hit = 1'b1;
                        end else begin
                            n_day   = DAY_W'(LONG_MONTH);
                            n_month = MONTH_W'(LAST_MONTH);
                            n_year  = r_cur_year - YEAR_W'(1);
                            n_m400  = (r_cur_m400 == '0) ?
                                      CYCLE_W'(YEAR_CYCLE - 1) : r_cur_m400 - CYCLE_W'(1);
                        end
                    end else begin
                        n_month = w_prev_month;
                        n_day   = month_length(w_prev_month, w_cur_leap);
                    end
                end else begin
                    n_day = r_cur_day - DAY_W'(1);
                end
            end
            default: begin
                // unused mode: report the date unchanged
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day   <= DAY_W'(1);
            r_cur_month <= MONTH_W'(1);
            r_cur_year  <= YEAR_W'(1);
            r_cur_m400  <= CYCLE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_cur_day   <= n_day;
                r_cur_month <= n_month;
                r_cur_year  <= n_year;
                r_cur_m400  <= n_m400;
            end
            if (o_adv) begin
                r_out_valid <= i_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_bad   <= n_bad;
            r_hit   <= n_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_day       = r_day;
    assign o_month     = r_month;
    assign o_year      = r_year;
    assign o_bad_load  = r_bad;
    assign o_range_hit = r_hit;

endmodule

[src/calendar_date_up_down_counter.sv]
// Gregorian date counter. Each transaction carries a mode (load, next day,
// previous day) and load fields; each returns one result with the date after
// the operation plus bad_load and range_hit flags. A refused load or a step
// past MAX_YEAR-12-31 or before 0-01-01 leaves the date unchanged. The date
// resets to 0001-01-01. A transaction passes through an input register, which
// also holds the load year's quotient by 400, and the result register, with
// date logic and the date state updated in the same cycle. One transaction
// is accepted every cycle while results are taken; the leap rule uses a
// year-modulo-400 counter kept next to the date.
`include "calendar_date_up_down_counter_assert.svh"

module calendar_date_up_down_counter
    import caldate_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [DAY_W-1:0]   i_load_day,
    input  logic [MONTH_W-1:0] i_load_month,
    input  logic [YEAR_W-1:0]  i_load_year,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [DAY_W-1:0]   o_day,
    output logic [MONTH_W-1:0] o_month,
    output logic [YEAR_W-1:0]  o_year,
    output logic               o_bad_load,
    output logic               o_range_hit
);

    logic     w_s1_valid;
    t_s1_item w_s1_item;
    logic     w_adv;

    caldate_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_load_day   (i_load_day),
        .i_load_month (i_load_month),
        .i_load_year  (i_load_year),
        .i_adv        (w_adv),
        .o_s1_valid   (w_s1_valid),
        .o_s1_item    (w_s1_item)
    );

    caldate_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (w_s1_valid),
        .i_s1_item   (w_s1_item),
        .o_adv       (w_adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_day       (o_day),
        .o_month     (o_month),
        .o_year      (o_year),
        .o_bad_load  (o_bad_load),
        .o_range_hit (o_range_hit)
    );

    // an accepted transaction always sits in the input register next cycle
    `CALDATE_ASSERT_NEXT(a_accept_loads_s1, i_clk, i_rst_n, i_in_valid && o_in_ready, w_s1_valid)

    // input side only stalls when both stages are full and the sink is stalled
    `CALDATE_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready)

    `CALDATE_ASSERT_IMPL(a_flags_exclusive, i_clk, i_rst_n, o_out_valid, !(o_bad_load && o_range_hit))

    // a refused step only happens on the first or last representable date
    `CALDATE_ASSERT_IMPL(a_range_at_edge, i_clk, i_rst_n, o_out_valid && o_range_hit, (o_day == DAY_W'(LONG_MONTH) && o_month == MONTH_W'(LAST_MONTH) && o_year == YEAR_W'(MAX_YEAR)) || (o_day == DAY_W'(1) && o_month == MONTH_W'(1) && o_year == '0))

    `CALDATE_ASSERT_IMPL(a_date_sane, i_clk, i_rst_n, o_out_valid, o_day != '0 && o_month != '0 && o_month <= MONTH_W'(LAST_MONTH))

endmodule

[sim/tb_top.sv]
module tb_top;
    import caldate_pkg::*;

    // mode code the block leaves unused, it must hold the date and clear both flags
    localparam logic [1:0] MODE_IDLE = 2'd3;

    localparam int RAND_ITEMS  = 1600;
    localparam int QUIET_ITEMS = 200;
    localparam int LONG_HOLD   = 40;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               bad_load;
        logic               range_hit;
    } t_date_res;

    typedef struct packed {
        logic [1:0]         mode;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               typed;
        t_date_res          res;
    } t_date_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_mode;
    logic [DAY_W-1:0]   i_load_day;
    logic [MONTH_W-1:0] i_load_month;
    logic [YEAR_W-1:0]  i_load_year;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [DAY_W-1:0]   o_day;
    logic [MONTH_W-1:0] o_month;
    logic [YEAR_W-1:0]  o_year;
    logic               o_bad_load;
    logic               o_range_hit;

    calendar_date_up_down_counter uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_load_day   (i_load_day),
        .i_load_month (i_load_month),
        .i_load_year  (i_load_year),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_day        (o_day),
        .o_month      (o_month),
        .o_year       (o_year),
        .o_bad_load   (o_bad_load),
        .o_range_hit  (o_range_hit)
    );

    always #1 i_clk = ~i_clk;

    // predicted calendar state
    int cal_day;
    int cal_month;
    int cal_year;

    t_date_res expected_dates[$];
    t_date_row date_rows[$];
    int        err_cnt       = 0;
    int        cycle_cnt     = 0;
    bit        tx_idle_on    = 1'b1;
    bit        rx_idle_on    = 1'b1;
    bit        long_hold_due = 1'b0;

    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 2) begin
            return leap_year(y) ? FEB_LEAP : FEB_PLAIN;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return SHORT_MONTH;
        end
        return LONG_MONTH;
    endfunction

    function automatic t_date_res apply_date_op(input logic [1:0] md, input int ld,
                                                input int lm, input int ly);
        t_date_res r;
        r = '0;
        case (md)
            MODE_LOAD: begin
                if (lm >= 1 && lm <= LAST_MONTH && ly <= MAX_YEAR &&
                    ld >= 1 && ld <= days_in_month(lm, ly)) begin
                    cal_day   = ld;
                    cal_month = lm;
                    cal_year  = ly;
                end else begin
                    r.bad_load = 1'b1;
                end
            end
            MODE_NEXT: begin
                if (cal_day >= days_in_month(cal_month, cal_year)) begin
                    if (cal_month >= LAST_MONTH) begin
                        if (cal_year >= MAX_YEAR) begin
                            r.range_hit = 1'b1;
                        end else begin
                            cal_day   = 1;
                            cal_month = 1;
                            cal_year  = cal_year + 1;
                        end
                    end else begin
                        cal_day   = 1;
                        cal_month = cal_month + 1;
                    end
                end else begin
                    cal_day = cal_day + 1;
                end
            end
            MODE_PREV: begin
                if (cal_day <= 1) begin
                    if (cal_month <= 1) begin
                        if (cal_year == 0) begin
                            r.range_hit = 1'b1;
                        end else begin
                            cal_day   = LONG_MONTH;
                            cal_month = LAST_MONTH;
                            cal_year  = cal_year - 1;
                        end
                    end else begin
                        cal_month = cal_month - 1;
                        cal_day   = days_in_month(cal_month, cal_year);
                    end
                end else begin
                    cal_day = cal_day - 1;
                end
            end
            default: begin
            end
        endcase
        r.day   = DAY_W'(cal_day);
        r.month = MONTH_W'(cal_month);
        r.year  = YEAR_W'(cal_year);
        return r;
    endfunction

    function automatic logic [YEAR_W-1:0] pick_year();
        case ($urandom_range(0, 5))
            0: return YEAR_W'($urandom_range(0, MAX_YEAR));
            1: return YEAR_W'($urandom_range(0, 2));
            2: return YEAR_W'($urandom_range(MAX_YEAR - 2, MAX_YEAR));
            3: return YEAR_W'(100 * $urandom_range(0, 99));
            4: return YEAR_W'(4 * $urandom_range(0, 2499));
            default: return YEAR_W'($urandom);
        endcase
    endfunction

    task automatic add_row(input logic [1:0] md, input int d, input int m, input int y,
                           input bit typed, input int ed, input int em, input int ey,
                           input bit eb, input bit eh);
        t_date_row row;
        row.mode            = md;
        row.day             = DAY_W'(d);
        row.month           = MONTH_W'(m);
        row.year            = YEAR_W'(y);
        row.typed           = typed;
        row.res.day         = DAY_W'(ed);
        row.res.month       = MONTH_W'(em);
        row.res.year        = YEAR_W'(ey);
        row.res.bad_load    = eb;
        row.res.range_hit   = eh;
        date_rows.push_back(row);
    endtask

    // offer one transaction, record what the block must answer once it is taken
    task automatic offer_date_op(input logic [1:0] md, input logic [DAY_W-1:0] d,
                                 input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y,
                                 input bit typed, input t_date_res typed_res);
        t_date_res pred;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= md;
        i_load_day   <= d;
        i_load_month <= m;
        i_load_year  <= y;
        do @(posedge i_clk); while (!o_in_ready);
        pred = apply_date_op(md, int'(d), int'(m), int'(y));
        expected_dates.push_back(typed ? typed_res : pred);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_date_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d-%0d-%0d", $time,
                         o_year, o_month, o_day);
                err_cnt++;
            end else begin
                e = expected_dates.pop_front();
                check_field("day", int'(e.day), int'(o_day));
                check_field("month", int'(e.month), int'(o_month));
                check_field("year", int'(e.year), int'(o_year));
                check_field("bad_load", int'(e.bad_load), int'(o_bad_load));
                check_field("range_hit", int'(e.range_hit), int'(o_range_hit));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: short random stalls, and a long hold-off when asked for
    initial begin
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [1:0]         md;
        logic [1:0]         run_dir;
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        int                 run_left;
        int                 r;
        t_date_row          row;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_mode       <= MODE_LOAD;
        i_load_day   <= '0;
        i_load_month <= '0;
        i_load_year  <= '0;
        run_left     = 0;
        run_dir      = MODE_NEXT;

        // after reset, the bottom and top of the range, refused loads, leap rules
        add_row(MODE_PREV, 0, 0, 0, 1, 31, 12, 0, 0, 0);
        add_row(MODE_LOAD, 1, 1, 0, 1, 1, 1, 0, 0, 0);
        add_row(MODE_PREV, 0, 0, 0, 1, 1, 1, 0, 0, 1);
        add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 31, 12, 9999, 1, 31, 12, 9999, 0, 0);
        add_row(MODE_NEXT, 0, 0, 0, 1, 31, 12, 9999, 0, 1);
        add_row(MODE_LOAD, 0, 1, 2000, 1, 31, 12, 9999, 1, 0);
        add_row(MODE_LOAD, 1, 0, 2000, 1, 31, 12, 9999, 1, 0);
        add_row(MODE_LOAD, 1, 13, 2000, 1, 31, 12, 9999, 1, 0);
        add_row(MODE_LOAD, 31, 15, 16383, 1, 31, 12, 9999, 1, 0);
        add_row(MODE_LOAD, 1, 1, 10000, 1, 31, 12, 9999, 1, 0);
        add_row(MODE_LOAD, 29, 2, 1900, 1, 31, 12, 9999, 1, 0);
        add_row(MODE_LOAD, 29, 2, 2000, 1, 29, 2, 2000, 0, 0);
        add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_PREV, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 29, 2, 2023, 1, 29, 2, 2000, 1, 0);
        add_row(MODE_LOAD, 30, 4, 2024, 1, 30, 4, 2024, 0, 0);
        add_row(MODE_LOAD, 31, 4, 2024, 1, 30, 4, 2024, 1, 0);
        add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 1, 3, 2100, 1, 1, 3, 2100, 0, 0);
        add_row(MODE_PREV, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LOAD, 1, 1, 2000, 1, 1, 1, 2000, 0, 0);
        add_row(MODE_PREV, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_IDLE, 31, 15, 16383, 0, 0, 0, 0, 0, 0);
        add_row(MODE_NEXT, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cal_day   = 1;
        cal_month = 1;
        cal_year  = 1;

        foreach (date_rows[i]) begin
            row = date_rows[i];
            offer_date_op(row.mode, row.day, row.month, row.year, row.typed, row.res);
        end

        // random loads, many near month ends and range edges, mixed with runs of steps mostly in one direction
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                tx_idle_on = ($urandom_range(0, 2) != 0);
                rx_idle_on = ($urandom_range(0, 2) != 0);
            end
            if (n >= RAND_ITEMS - QUIET_ITEMS) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (n == 400 || n == 1100) begin
                long_hold_due = 1'b1;
            end
            if (run_left == 0 && $urandom_range(0, 2) == 0) begin
                md = MODE_LOAD;
                r  = $urandom_range(0, 9);
                if (r < 2) begin
                    d = DAY_W'($urandom);
                    m = MONTH_W'($urandom);
                    y = YEAR_W'($urandom);
                end else if (r == 2) begin
                    // anchor at a range edge
                    if ($urandom_range(0, 1)) begin
                        d = DAY_W'($urandom_range(1, 3));
                        m = MONTH_W'(1);
                        y = '0;
                    end else begin
                        d = DAY_W'($urandom_range(29, 31));
                        m = MONTH_W'(LAST_MONTH);
                        y = YEAR_W'(MAX_YEAR);
                    end
                end else begin
                    m = MONTH_W'($urandom_range(1, LAST_MONTH));
                    d = DAY_W'(($urandom_range(0, 2) != 0) ? $urandom_range(26, 31)
                                                           : $urandom_range(1, 31));
                    y = pick_year();
                end
            end else begin
                if (run_left == 0) begin
                    run_dir  = $urandom_range(0, 1) ? MODE_NEXT : MODE_PREV;
                    run_left = $urandom_range(1, 24);
                end
                run_left--;
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    md = MODE_IDLE;
                end else if (r == 1) begin
                    md = (run_dir == MODE_NEXT) ? MODE_PREV : MODE_NEXT;
                end else begin
                    md = run_dir;
                end
                d = DAY_W'($urandom);
                m = MONTH_W'($urandom);
                y = YEAR_W'($urandom);
            end
            offer_date_op(md, d, m, y, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
